// File: hdl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg
// Types and codes shared by the TGA run-length pixel decoder modules.
// ----------------------------------------------------------------------------
package tgarle_pkg;

	// result kinds
	localparam logic [1:0] KIND_RUN     = 2'd0;
	localparam logic [1:0] KIND_BAD_HDR = 2'd1;
	localparam logic [1:0] KIND_TRUNC   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} byte_req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [7:0]  repeat_count;
		logic [31:0] first_index;
		logic        image_done;
	} result_t;

	// header parser status toward the phase control
	typedef struct packed {
		logic        last;
		logic        bad;
		logic        compressed;
		logic        is32;
		logic        total_zero;
		logic [31:0] total;
	} hdr_stat_t;

	// byte steering into the pixel unit
	typedef struct packed {
		logic start;
		logic packet;
		logic pixel;
	} pix_ctl_t;

	typedef struct packed {
		logic        fire;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic [7:0]  count;
		logic [31:0] first_index;
		logic        done;
		logic        need_packet;
		logic [31:0] pixels_done_nx;
	} pix_res_t;

endpackage

// File: hdl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Streaming TGA true-color decoder: header check, raw and RLE pixel packets.
// ----------------------------------------------------------------------------
// Usage:
// - byte channel: one file byte per request (byte_data), end_of_file set on
//   the last byte. Header first, then pixel data, in file order.
// - result channel: zero or one result per byte. kind RUN carries a color,
//   a repeat count (1..128) and the file-order index of the first pixel;
//   kind BAD_HDR reports an unsupported header, kind TRUNC an early end of
//   file (first_index = pixels decoded so far).
// - Each byte is registered, then decoded into the result register, from
//   which its result, if any, shows on result_valid.
// - Throughput is one byte per cycle while the result register is not
//   stalled, set by the single decode stage between input and result register.
// - A stalled result register holds the input register; byte_ready drops
//   only while both are full and result_ready is low.
// - Reset (arst_n low) empties both registers and returns the parser to the
//   start of a header; every end_of_file byte also returns the parser there.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  tgarle_pkg::byte_req_t byte_data,
	output logic                  result_valid,
	input  logic                  result_ready,
	output tgarle_pkg::result_t   result_data
);
	import tgarle_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_PACKET = 2'd1;
	localparam logic [1:0] PH_PIXEL  = 2'd2;
	localparam logic [1:0] PH_IDLE   = 2'd3;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;

	logic [1:0]  phase_q;
	logic [1:0]  phase_nx;
	logic        out_free;
	logic        proc;
	logic        res_fire;
	result_t     res;
	hdr_stat_t   hdr;
	pix_ctl_t    pctl;
	pix_res_t    pres;
	logic        hdr_step;
	logic        clear;

	assign out_free   = !result_valid || result_ready;
	assign byte_ready = !valid_s1 || out_free;
	assign proc       = valid_s1 && out_free;
	assign hdr_step   = proc && (phase_q == PH_HEADER);
	assign clear      = proc && eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_ready)
			valid_s1 <= byte_valid;
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_data.data_byte;
			eof_s1  <= byte_data.end_of_file;
		end
	end

	tgarle_hdr u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (hdr_step),
		.clear     (clear),
		.data_byte (byte_s1),
		.stat      (hdr)
	);

	tgarle_pix u_pix (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (clear),
		.ctl        (pctl),
		.data_byte  (byte_s1),
		.compressed (hdr.compressed),
		.is32       (hdr.is32),
		.total      (hdr.total),
		.res        (pres)
	);

	always_comb begin
		pctl     = '0;
		phase_nx = phase_q;
		res      = '0;
		res_fire = 1'b0;

		if (proc) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr.last) begin
						if (hdr.bad) begin
							res.kind = KIND_BAD_HDR;
							res_fire = 1'b1;
							phase_nx = PH_IDLE;
						end else if (hdr.total_zero) begin
							phase_nx = PH_IDLE;
						end else begin
							pctl.start = 1'b1;
							phase_nx   = hdr.compressed ? PH_PACKET : PH_PIXEL;
						end
					end
				end
				PH_PACKET: begin
					pctl.packet = 1'b1;
					phase_nx    = PH_PIXEL;
				end
				PH_PIXEL: begin
					pctl.pixel = 1'b1;
					if (pres.fire) begin
						res.kind         = KIND_RUN;
						res.blue         = pres.blue;
						res.green        = pres.green;
						res.red          = pres.red;
						res.alpha        = pres.alpha;
						res.repeat_count = pres.count;
						res.first_index  = pres.first_index;
						res.image_done   = pres.done;
						res_fire         = 1'b1;
						if (pres.done)
							phase_nx = PH_IDLE;
						else if (pres.need_packet)
							phase_nx = PH_PACKET;
					end
				end
				PH_IDLE: ;
				default: ;
			endcase

			// an unfinished file overrides whatever this byte produced
			if (eof_s1) begin
				if (phase_nx != PH_IDLE) begin
					res             = '0;
					res.kind        = KIND_TRUNC;
					res.first_index = pres.pixels_done_nx;
					res_fire        = 1'b1;
				end
				phase_nx = PH_HEADER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			result_valid <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			if (out_free)
				result_valid <= res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_fire)
			result_data <= res;
	end

	// end of file always rewinds to header parsing
	a_eof_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		proc && eof_s1 |=> phase_q == PH_HEADER)
		else $error("phase not rewound after end of file");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proc && phase_q == PH_IDLE && !eof_s1 |-> !res_fire)
		else $error("result produced while ignoring trailing bytes");

	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.kind == KIND_RUN |-> result_data.repeat_count != 8'd0)
		else $error("pixel run with zero repeat count");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.kind != KIND_RUN
			|-> result_data.repeat_count == 8'd0 && !result_data.image_done)
		else $error("status result carries pixel fields");

endmodule

// File: hdl/tgarle_hdr.sv
// ----------------------------------------------------------------------------
// tgarle_hdr
// Parses the 18-byte TGA header, checks it and registers the pixel total.
// ----------------------------------------------------------------------------
module tgarle_hdr (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  clear,
	input  logic [7:0]            data_byte,
	output tgarle_pkg::hdr_stat_t stat
);
	import tgarle_pkg::*;

	localparam logic [4:0] HDR_ID_LEN   = 5'd0;
	localparam logic [4:0] HDR_CMAP     = 5'd1;
	localparam logic [4:0] HDR_TYPE     = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
	localparam logic [4:0] HDR_HGT_LO   = 5'd14;
	localparam logic [4:0] HDR_HGT_HI   = 5'd15;
	localparam logic [4:0] HDR_DEPTH    = 5'd16;
	localparam logic [4:0] HDR_LAST     = 5'd17;

	localparam logic [7:0] TYPE_RAW = 8'd2;
	localparam logic [7:0] TYPE_RLE = 8'd10;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	logic [4:0]  pos_q;
	logic        bad_q;
	logic        compressed_q;
	logic        is32_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			bad_q        <= 1'b0;
			compressed_q <= 1'b0;
			is32_q       <= 1'b0;
		end else if (clear) begin
			pos_q        <= '0;
			bad_q        <= 1'b0;
			compressed_q <= 1'b0;
			is32_q       <= 1'b0;
		end else if (step) begin
			pos_q <= pos_q + 5'd1;
			unique case (pos_q)
				HDR_ID_LEN, HDR_CMAP: begin
					if (data_byte != 8'd0)
						bad_q <= 1'b1;
				end
				HDR_TYPE: begin
					if (data_byte == TYPE_RAW)
						compressed_q <= 1'b0;
					else if (data_byte == TYPE_RLE)
						compressed_q <= 1'b1;
					else
						bad_q <= 1'b1;
				end
				HDR_DEPTH: begin
					if (data_byte == DEPTH_24)
						is32_q <= 1'b0;
					else if (data_byte == DEPTH_32)
						is32_q <= 1'b1;
					else
						bad_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// geometry; total is ready one byte ahead of the header end
	always_ff @(posedge clk) begin
		if (step) begin
			unique case (pos_q)
				HDR_WIDTH_LO: width_q[7:0]   <= data_byte;
				HDR_WIDTH_HI: width_q[15:8]  <= data_byte;
				HDR_HGT_LO:   height_q[7:0]  <= data_byte;
				HDR_HGT_HI:   height_q[15:8] <= data_byte;
				HDR_DEPTH:    total_q        <= {16'd0, width_q} * {16'd0, height_q};
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.last       = (pos_q == HDR_LAST);
		stat.bad        = bad_q;
		stat.compressed = compressed_q;
		stat.is32       = is32_q;
		stat.total      = total_q;
		stat.total_zero = (total_q == 32'd0);
	end

endmodule

// File: hdl/tgarle_pix.sv
// ----------------------------------------------------------------------------
// tgarle_pix
// Packet header decode, pixel byte assembly and run/pixel accounting.
// ----------------------------------------------------------------------------
module tgarle_pix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  tgarle_pkg::pix_ctl_t ctl,
	input  logic [7:0]           data_byte,
	input  logic                 compressed,
	input  logic                 is32,
	input  logic [31:0]          total,
	output tgarle_pkg::pix_res_t res
);
	import tgarle_pkg::*;

	localparam logic [7:0] RUN_BIAS = 8'd127;

	logic [7:0]  rem_q;
	logic        run_q;
	logic [1:0]  bip_q;
	logic [23:0] asm_q;
	logic [31:0] done_q;
	logic [31:0] left_q;

	logic [1:0]  last_k;
	logic        finish;
	logic        run;
	logic [7:0]  run_cnt;
	logic [7:0]  count;
	logic [31:0] left_nx;
	logic [7:0]  rem_nx;
	logic [7:0]  pkt_rem;

	always_comb begin
		last_k = is32 ? 2'd3 : 2'd2;
		finish = ctl.pixel && (bip_q == last_k);
		run    = compressed && run_q;

		// clip a run to the pixels still missing
		if (left_q[31:8] != 24'd0 || rem_q <= left_q[7:0])
			run_cnt = rem_q;
		else
			run_cnt = left_q[7:0];
		if (run_cnt == 8'd0)
			run_cnt = 8'd1;
		count   = run ? run_cnt : 8'd1;
		left_nx = left_q - {24'd0, count};

		rem_nx = rem_q;
		if (run)
			rem_nx = 8'd0;
		else if (compressed && rem_q != 8'd0)
			rem_nx = rem_q - 8'd1;

		pkt_rem = data_byte[7] ? data_byte - RUN_BIAS : data_byte + 8'd1;

		res.fire           = finish;
		res.blue           = asm_q[7:0];
		res.green          = asm_q[15:8];
		res.red            = is32 ? asm_q[23:16] : data_byte;
		res.alpha          = is32 ? data_byte : 8'hFF;
		res.count          = count;
		res.first_index    = done_q;
		res.done           = (left_nx == 32'd0);
		res.need_packet    = compressed && (rem_nx == 8'd0);
		res.pixels_done_nx = finish ? done_q + {24'd0, count} : done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			run_q  <= 1'b0;
			bip_q  <= '0;
			done_q <= '0;
			left_q <= '0;
		end else if (clear) begin
			rem_q  <= '0;
			run_q  <= 1'b0;
			bip_q  <= '0;
			done_q <= '0;
			left_q <= '0;
		end else if (ctl.start) begin
			rem_q  <= '0;
			bip_q  <= '0;
			left_q <= total;
		end else if (ctl.packet) begin
			run_q <= data_byte[7];
			rem_q <= pkt_rem;
			bip_q <= '0;
		end else if (ctl.pixel) begin
			if (finish) begin
				bip_q  <= '0;
				rem_q  <= rem_nx;
				left_q <= left_nx;
				done_q <= res.pixels_done_nx;
			end else begin
				bip_q <= bip_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pixel) begin
			unique case (bip_q)
				2'd0: asm_q[7:0]   <= data_byte;
				2'd1: asm_q[15:8]  <= data_byte;
				2'd2: asm_q[23:16] <= data_byte;
				default: ;
			endcase
		end
	end

endmodule

// File: test/tga_rle_pixel_decoder_test.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_test
// Self-checking bench for the TGA run-length pixel decoder. Whole TGA files
// (good, bad, empty, cut short, raw and RLE, 24 and 32 bit) are fed one byte
// per request; a local decoder model predicts every result, which is checked
// field by field as it leaves the block, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_test;
	import tgarle_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [1:0] {P_HDR, P_PKT, P_PIX, P_SKIP} parse_phase_t;

	localparam int          HDR_LEN      = 18;
	localparam int          HDR_ID_LEN   = 0;
	localparam int          HDR_CMAP     = 1;
	localparam int          HDR_TYPE     = 2;
	localparam int          HDR_W_LO     = 12;
	localparam int          HDR_W_HI     = 13;
	localparam int          HDR_H_LO     = 14;
	localparam int          HDR_H_HI     = 15;
	localparam int          HDR_DEPTH    = 16;
	localparam logic [7:0]  TGA_TYPE_RAW = 8'd2;
	localparam logic [7:0]  TGA_TYPE_RLE = 8'd10;
	localparam logic [7:0]  DEPTH_24     = 8'd24;
	localparam logic [7:0]  DEPTH_32     = 8'd32;
	localparam logic [7:0]  RUN_FLAG     = 8'd128;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_ready;
	byte_req_t byte_data;
	logic      result_valid;
	logic      result_ready;
	result_t   result_data;

	tga_rle_pixel_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	// decoder model state
	parse_phase_t ph;
	int           hdr_pos;
	logic [15:0]  img_w;
	logic [15:0]  img_h;
	logic         rle;
	logic         wide;
	logic         hdr_bad;
	logic         pkt_run;
	logic [7:0]   pkt_left;
	logic [1:0]   pix_byte;
	logic [31:0]  pix_word;
	logic [31:0]  pix_count;

	result_t decoded_q[$];
	int      decoded_bytes;   // bytes the block did not just skip
	int      mismatches;
	int      send_idle_pct;
	int      recv_idle_pct;
	int      hold_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void clear_decoder();
		ph        = P_HDR;
		hdr_pos   = 0;
		img_w     = '0;
		img_h     = '0;
		rle       = 1'b0;
		wide      = 1'b0;
		hdr_bad   = 1'b0;
		pkt_run   = 1'b0;
		pkt_left  = '0;
		pix_byte  = '0;
		pix_word  = '0;
		pix_count = '0;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eof);
		result_t     r;
		logic        emit;
		logic [31:0] total;
		logic [31:0] left;
		logic [31:0] count;
		int          k;
		r    = '0;
		emit = 1'b0;
		if (ph != P_SKIP)
			decoded_bytes++;
		case (ph)
			P_HDR: begin
				case (hdr_pos)
					HDR_ID_LEN, HDR_CMAP: if (b != 8'd0) hdr_bad = 1'b1;
					HDR_TYPE: begin
						if (b == TGA_TYPE_RAW) rle = 1'b0;
						else if (b == TGA_TYPE_RLE) rle = 1'b1;
						else hdr_bad = 1'b1;
					end
					HDR_W_LO: img_w[7:0]  = b;
					HDR_W_HI: img_w[15:8] = b;
					HDR_H_LO: img_h[7:0]  = b;
					HDR_H_HI: img_h[15:8] = b;
					HDR_DEPTH: begin
						if (b == DEPTH_24) wide = 1'b0;
						else if (b == DEPTH_32) wide = 1'b1;
						else hdr_bad = 1'b1;
					end
					default: ;
				endcase
				hdr_pos++;
				if (hdr_pos == HDR_LEN) begin
					total = {16'd0, img_w} * {16'd0, img_h};
					if (hdr_bad) begin
						r.kind = KIND_BAD_HDR;
						emit   = 1'b1;
						ph     = P_SKIP;
					end else if (total == 0) begin
						ph = P_SKIP;
					end else begin
						ph       = rle ? P_PKT : P_PIX;
						pkt_left = '0;
						pix_byte = '0;
					end
				end
			end
			P_PKT: begin
				pkt_run  = b[7];
				pkt_left = pkt_run ? b - 8'd127 : b + 8'd1;
				pix_byte = '0;
				ph       = P_PIX;
			end
			P_PIX: begin
				k = pix_byte;
				if (k == 0) pix_word = {24'd0, b};
				else pix_word[8*k +: 8] = b;
				k++;
				pix_byte = 2'(k);
				if (k == (wide ? 4 : 3)) begin
					total    = {16'd0, img_w} * {16'd0, img_h};
					left     = total - pix_count;
					count    = 1;
					pix_byte = '0;
					if (rle && pkt_run) begin
						// a run never spills past the image
						count = ({24'd0, pkt_left} < left) ? {24'd0, pkt_left} : left;
						if (count == 0) count = 1;
						pkt_left = '0;
					end else if (rle && pkt_left != 0) begin
						pkt_left--;
					end
					r.kind         = KIND_RUN;
					r.blue         = pix_word[7:0];
					r.green        = pix_word[15:8];
					r.red          = pix_word[23:16];
					r.alpha        = wide ? pix_word[31:24] : 8'hFF;
					r.repeat_count = count[7:0];
					r.first_index  = pix_count;
					pix_count      = pix_count + count;
					if (pix_count >= total) begin
						r.image_done = 1'b1;
						ph           = P_SKIP;
					end else if (rle && pkt_left == 0) begin
						ph = P_PKT;
					end
					emit = 1'b1;
				end
			end
			default: ;
		endcase
		if (eof) begin
			// end of file mid-decode overrides whatever this byte produced
			if (ph != P_SKIP) begin
				r             = '0;
				r.kind        = KIND_TRUNC;
				r.first_index = pix_count;
				emit          = 1'b1;
			end
			clear_decoder();
		end
		if (emit)
			decoded_q.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("%0t mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	// result side: check, then pick ready for the next cycle
	initial begin
		result_t got_r;
		result_t want_r;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				got_r = result_data;
				if (decoded_q.size() == 0) begin
					report_mismatch("result with nothing pending", got_r.kind, 0);
				end else begin
					want_r = decoded_q.pop_front();
					if (got_r.kind !== want_r.kind)
						report_mismatch("kind", got_r.kind, want_r.kind);
					if (got_r.blue !== want_r.blue)
						report_mismatch("blue", got_r.blue, want_r.blue);
					if (got_r.green !== want_r.green)
						report_mismatch("green", got_r.green, want_r.green);
					if (got_r.red !== want_r.red)
						report_mismatch("red", got_r.red, want_r.red);
					if (got_r.alpha !== want_r.alpha)
						report_mismatch("alpha", got_r.alpha, want_r.alpha);
					if (got_r.repeat_count !== want_r.repeat_count)
						report_mismatch("repeat_count", got_r.repeat_count,
							want_r.repeat_count);
					if (got_r.first_index !== want_r.first_index)
						report_mismatch("first_index", got_r.first_index,
							want_r.first_index);
					if (got_r.image_done !== want_r.image_done)
						report_mismatch("image_done", got_r.image_done, want_r.image_done);
				end
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eof);
		if ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		byte_valid <= 1'b1;
		byte_data  <= '{data_byte: b, end_of_file: eof};
		do @(posedge clk); while (!byte_ready);
		decode_byte(b, eof);
	endtask

	task automatic send_file(ref byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	// stop offering and wait for every pending result, then let the pipe settle
	task automatic drain(input int settle);
		byte_valid <= 1'b0;
		do @(posedge clk); while (decoded_q.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(posedge clk);
	endtask

	// little-endian, n low bytes of word
	function automatic void put_bytes(ref byte_q_t q, input logic [31:0] word, input int n);
		for (int i = 0; i < n; i++)
			q.push_back(word[8*i +: 8]);
	endfunction

	function automatic void put_header(ref byte_q_t q, input logic [7:0] id_len,
			input logic [7:0] cmap, input logic [7:0] img_type, input logic [15:0] w,
			input logic [15:0] h, input logic [7:0] depth);
		q.push_back(id_len);
		q.push_back(cmap);
		q.push_back(img_type);
		repeat (9) q.push_back(8'($urandom));
		put_bytes(q, {h, w}, 4);
		q.push_back(depth);
		q.push_back(8'($urandom));
	endfunction

	function automatic void put_pixels(ref byte_q_t q, input int n, input logic is32);
		repeat (n * (is32 ? 4 : 3)) begin
			case ($urandom_range(7))
				0: q.push_back(8'h00);
				1: q.push_back(8'hFF);
				default: q.push_back(8'($urandom));
			endcase
		end
	endfunction

	function automatic void put_rle(ref byte_q_t q, input int npix, input logic is32,
			input int max_pkt, input int run_pct);
		int covered;
		int n;
		covered = 0;
		while (covered < npix) begin
			n = $urandom_range(max_pkt - 1);
			if ($urandom_range(99) < run_pct) begin
				q.push_back(RUN_FLAG + 8'(n));
				put_pixels(q, 1, is32);
			end else begin
				q.push_back(8'(n));
				put_pixels(q, n + 1, is32);
			end
			covered += n + 1;
		end
	endfunction

	function automatic void random_file(ref byte_q_t q);
		int          pick;
		int          max_pkt;
		int          cut;
		logic        is32;
		logic        packed_rle;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  bad_val;
		pick       = $urandom_range(99);
		is32       = $urandom_range(1);
		packed_rle = $urandom_range(1);
		max_pkt    = ($urandom_range(3) == 0) ? 128 : $urandom_range(1, 6);
		q.delete();
		if (pick < 60) begin
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 4);
			put_header(q, 0, 0, packed_rle ? TGA_TYPE_RLE : TGA_TYPE_RAW, w, h,
				is32 ? DEPTH_32 : DEPTH_24);
			if (packed_rle) put_rle(q, w * h, is32, max_pkt, 50);
			else put_pixels(q, w * h, is32);
			case ($urandom_range(5))
				0: begin
					cut = $urandom_range(1, q.size() - 1);
					while (q.size() > cut) void'(q.pop_back());
				end
				1: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
				default: ;
			endcase
		end else if (pick < 66) begin
			// wide image made of long runs
			w = $urandom_range(129, 700);
			h = $urandom_range(1, 2);
			put_header(q, 0, 0, TGA_TYPE_RLE, w, h, is32 ? DEPTH_32 : DEPTH_24);
			put_rle(q, w * h, is32, 128, 90);
		end else if (pick < 74) begin
			// huge dimensions, file ends after a few pixels
			w = $urandom_range(1, 65535);
			h = $urandom_range(1, 65535);
			put_header(q, 0, 0, packed_rle ? TGA_TYPE_RLE : TGA_TYPE_RAW, w, h,
				is32 ? DEPTH_32 : DEPTH_24);
			if (packed_rle) put_rle(q, $urandom_range(1, 5), is32, max_pkt, 50);
			else put_pixels(q, $urandom_range(1, 5), is32);
		end else if (pick < 84) begin
			bad_val = $urandom_range(255);
			if (bad_val == TGA_TYPE_RAW || bad_val == TGA_TYPE_RLE || bad_val == DEPTH_24 ||
					bad_val == DEPTH_32 || bad_val == 8'd0)
				bad_val = 8'd3;
			case ($urandom_range(3))
				0: put_header(q, bad_val, 0, TGA_TYPE_RAW, 16'($urandom), 16'($urandom),
					DEPTH_24);
				1: put_header(q, 0, bad_val, TGA_TYPE_RLE, 16'($urandom), 16'($urandom),
					DEPTH_32);
				2: put_header(q, 0, 0, bad_val, 16'($urandom), 16'($urandom),
					is32 ? DEPTH_32 : DEPTH_24);
				default: put_header(q, 0, 0, packed_rle ? TGA_TYPE_RLE : TGA_TYPE_RAW,
					16'($urandom), 16'($urandom), bad_val);
			endcase
			repeat ($urandom_range(3)) q.push_back(8'($urandom));
		end else if (pick < 92) begin
			w = $urandom_range(1, 65535);
			h = 16'd0;
			if ($urandom_range(1)) begin
				h = w;
				w = 16'd0;
			end
			put_header(q, 0, 0, packed_rle ? TGA_TYPE_RLE : TGA_TYPE_RAW, w, h,
				is32 ? DEPTH_32 : DEPTH_24);
			repeat ($urandom_range(3)) q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 24)) q.push_back(8'($urandom));
		end
	endfunction

	task automatic test_raw_images();
		byte_q_t q;
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd2, 16'd1, DEPTH_24);
		put_bytes(q, 32'h000000, 3);
		put_bytes(q, 32'hFFFFFF, 3);
		put_bytes(q, 32'hA55A, 2);          // trailing junk
		send_file(q);
		q.delete();
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd1, 16'd2, DEPTH_32);
		put_bytes(q, 32'h00FF00FF, 4);
		put_bytes(q, 32'hFF040201, 4);
		send_file(q);
	endtask

	task automatic test_rle_images();
		byte_q_t q;
		// 128-run, 1-run, then a 128-run clipped to the last pixel
		put_header(q, 0, 0, TGA_TYPE_RLE, 16'd130, 16'd1, DEPTH_24);
		q.push_back(8'hFF);
		put_bytes(q, 32'h332211, 3);
		q.push_back(RUN_FLAG);
		put_bytes(q, 32'h665544, 3);
		q.push_back(8'hFF);
		put_bytes(q, 32'h998877, 3);
		q.push_back(8'h00);
		send_file(q);
		q.delete();
		// second raw packet runs past the image
		put_header(q, 0, 0, TGA_TYPE_RLE, 16'd3, 16'd1, DEPTH_32);
		q.push_back(8'h01);
		put_bytes(q, 32'h80402010, 4);
		put_bytes(q, 32'h08040201, 4);
		q.push_back(8'h01);
		put_bytes(q, 32'h7F7E7D7C, 4);
		put_bytes(q, 32'hDEADBEEF, 4);
		send_file(q);
	endtask

	task automatic test_bad_headers();
		byte_q_t q;
		for (int c = 0; c < 4; c++) begin
			q.delete();
			put_header(q, (c == 0) ? 8'd1 : 8'd0, (c == 1) ? 8'd1 : 8'd0,
				(c == 2) ? 8'd3 : TGA_TYPE_RAW, 16'hFFFF, 16'h8000,
				(c == 3) ? 8'd16 : DEPTH_32);
			// last one ends right on the final header byte
			if (c != 3)
				put_bytes(q, 32'h1234, 2);
			send_file(q);
		end
	endtask

	task automatic test_empty_image();
		byte_q_t q;
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd0, 16'd5, DEPTH_24);
		put_bytes(q, 32'hFFFFFF, 3);
		send_file(q);
		q.delete();
		put_header(q, 0, 0, TGA_TYPE_RLE, 16'hFFFF, 16'd0, DEPTH_32);
		send_file(q);
	endtask

	task automatic test_truncation();
		byte_q_t q;
		// inside the header
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd2, 16'd2, DEPTH_24);
		while (q.size() > 5) void'(q.pop_back());
		send_file(q);
		// on the last header byte
		q.delete();
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd2, 16'd2, DEPTH_24);
		send_file(q);
		// inside a pixel
		q.delete();
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd2, 16'd2, DEPTH_24);
		put_bytes(q, 32'h010203, 3);
		put_bytes(q, 32'h0405, 2);
		send_file(q);
		// on the byte that finishes a pixel: truncation wins
		q.delete();
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd2, 16'd2, DEPTH_24);
		put_bytes(q, 32'h010203, 3);
		put_bytes(q, 32'h040506, 3);
		send_file(q);
		// on a packet byte
		q.delete();
		put_header(q, 0, 0, TGA_TYPE_RLE, 16'd3, 16'd3, DEPTH_32);
		q.push_back(8'h82);
		put_bytes(q, 32'hC0C1C2C3, 4);
		q.push_back(8'h00);
		send_file(q);
	endtask

	task automatic test_backpressure();
		byte_q_t q;
		drain(4);
		@(negedge clk);
		hold_left = 60;
		@(posedge clk);
		put_header(q, 0, 0, TGA_TYPE_RAW, 16'd4, 16'd4, DEPTH_32);
		put_pixels(q, 16, 1'b1);
		send_file(q);
		drain(4);
	endtask

	task automatic test_random_files(input int n_bytes);
		byte_q_t q;
		int      target;
		target = decoded_bytes + n_bytes;
		while (decoded_bytes < target) begin
			random_file(q);
			send_file(q);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		byte_valid    = 1'b0;
		byte_data     = '0;
		hold_left     = 0;
		mismatches    = 0;
		decoded_bytes = 0;
		send_idle_pct = 8;
		recv_idle_pct = 58;
		clear_decoder();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_raw_images();
		test_rle_images();
		test_bad_headers();
		test_empty_image();
		test_truncation();
		test_random_files(60);
		drain(4);

		set_idling(58, 8);
		test_random_files(60);
		drain(4);

		set_idling(0, 0);
		test_backpressure();
		test_random_files(60);
		drain(12);

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
